/* design/olt_pkg.sv */
// types and constants shared by the order lifecycle table
// no dependencies
package olt_pkg;

    localparam int unsigned KEY_W    = 31;
    localparam int unsigned SYM_W    = 16;
    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned QTY_W    = 24;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned REQ_W    = 3;

    localparam int unsigned S_TDATA_W = 136;
    localparam int unsigned S_TUSER_W = REQ_W;
    localparam int unsigned M_TDATA_W = 136;

    localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 3'd2;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd3;

    localparam logic [STATUS_W-1:0] ORD_PENDING  = 3'd0;
    localparam logic [STATUS_W-1:0] ORD_FILLED   = 3'd1;
    localparam logic [STATUS_W-1:0] ORD_CANCELED = 3'd2;
    localparam logic [STATUS_W-1:0] ORD_REJECTED = 3'd3;
    localparam logic [STATUS_W-1:0] ORD_PARTIAL  = 3'd4;

    localparam logic [1:0] OUT_DONE        = 2'd0;
    localparam logic [1:0] OUT_NOT_FOUND   = 2'd1;
    localparam logic [1:0] OUT_NOT_PENDING = 2'd2;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_NEW    = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;
    localparam logic [1:0] CMD_MODIFY = 2'd3;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MOD,
        FSM_RMW
    } fsm_t;

    typedef struct packed {
        logic [4:0]          pad;
        logic [QTY_W-1:0]    fill_amount;
        logic [STATUS_W-1:0] new_state;
        logic                buy_side;
        logic [QTY_W-1:0]    order_qty;
        logic [PRICE_W-1:0]  price_ticks;
        logic [SYM_W-1:0]    symbol_code;
        logic [KEY_W-1:0]    order_ref;
    } in_beat_t;

    typedef struct packed {
        logic                active;
        logic [QTY_W-1:0]    out_filled;
        logic [STATUS_W-1:0] out_state;
        logic                out_side;
        logic [QTY_W-1:0]    out_qty;
        logic [PRICE_W-1:0]  out_price;
        logic [SYM_W-1:0]    out_symbol;
        logic [1:0]          exchange_cmd;
        logic [KEY_W-1:0]    result_id;
        logic [1:0]          outcome;
    } out_beat_t;

    typedef struct packed {
        logic [KEY_W-1:0]    id;
        logic [SYM_W-1:0]    symbol;
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    qty;
        logic [QTY_W-1:0]    filled;
        logic                side;
        logic [STATUS_W-1:0] status;
    } slot_entry_t;

endpackage

/* design/olt_slot_mod.sv */
// slot index unit: order id modulo table depth by reciprocal multiply
// two register stages, one correction step; depends on olt_pkg
module olt_slot_mod #(
    parameter  int unsigned DEPTH = 1024,
    localparam int unsigned IDX_W = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic [olt_pkg::KEY_W-1:0] in_key,
    output logic                     out_valid,
    output logic [IDX_W-1:0]         out_slot
);
    import olt_pkg::*;

    localparam int unsigned LOG   = $clog2(DEPTH);
    localparam int unsigned SHIFT = KEY_W + LOG;
    localparam int unsigned PW    = KEY_W + 32;
    localparam int unsigned RW    = LOG + 1;
    localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / 64'(DEPTH);
    localparam logic [31:0] RECIP   = RECIP64[31:0];

    logic             v1_reg;
    logic             v2_reg;
    logic [KEY_W-1:0] key1_reg;
    logic [PW-1:0]    prod_reg;
    logic [RW-1:0]    rem_reg;
    logic [KEY_W-1:0] quo;
    logic [KEY_W-1:0] quo_d;
    logic [KEY_W-1:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            key1_reg <= in_key;
            prod_reg <= PW'(in_key) * PW'(RECIP);
        end
        if (v1_reg) begin
            rem_reg <= diff[RW-1:0];
        end
    end

    // quotient may be one low, remainder then lies below twice the depth
    always_comb begin
        quo   = KEY_W'(prod_reg >> SHIFT);
        quo_d = KEY_W'(quo * KEY_W'(DEPTH));
        diff  = key1_reg - quo_d;
    end

    assign out_valid = v2_reg;
    assign out_slot  = (rem_reg >= RW'(DEPTH)) ? IDX_W'(rem_reg - RW'(DEPTH))
                                               : IDX_W'(rem_reg);

endmodule

/* design/order_lifecycle_table_top.sv */
// order lifecycle table: top level with slot memory and request sequencer
// depends on olt_pkg and olt_slot_mod
//
// usage:
//   s_axis carries one request per beat: tuser is req_type, tdata packs
//   order_ref, symbol_code, price_ticks, order_qty, buy_side, new_state and
//   fill_amount from bit 0 up. m_axis returns exactly one result beat per
//   request, in request order.
//   a request passes through the reciprocal modulo unit that maps the order id
//   to a slot, one memory read and one read-modify-write step; the
//   read-modify-write step waits while m_axis still holds the previous result.
//   the next request is taken only once the current one is written back.
//   the slot memory is a single synchronous RAM of TABLE_DEPTH entries with
//   a registered read; one request is in flight, so no forwarding is needed.
//   reset clears the id counter, the fill count that marks written slots and
//   all handshakes; no clearing pass runs, requests are taken right away.
//   while m_axis is stalled the finished beat is held in the output register;
//   one more request is accepted and waits in its write-back cycle.
//
module order_lifecycle_table_top #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // order_ref, symbol_code, price_ticks, order_qty, buy_side, new_state, fill_amount
    input  logic [olt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [olt_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // outcome, result_id, exchange_cmd, out_symbol, out_price, out_qty,
    // out_side, out_state, out_filled, active
    output logic [olt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import olt_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);

    fsm_t state_reg;
    fsm_t state_next;

    logic s_ready;
    logic mod_start;
    logic rd_en;
    logic commit;
    logic out_free;

    in_beat_t         in_beat;
    logic [REQ_W-1:0] req_reg;
    in_beat_t         beat_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [KEY_W-1:0] id_counter_reg;
    logic [CW-1:0]    cnt_reg;

    logic             mod_valid;
    logic [IDX_W-1:0] mod_slot;
    logic [IDX_W-1:0] slot_reg;

    slot_entry_t slot_mem [TABLE_DEPTH];
    slot_entry_t rd_entry_reg;
    slot_entry_t wr_entry;
    logic        wr_en;
    logic        slot_written;
    logic        found;

    out_beat_t res_next;
    out_beat_t res_reg;
    logic      m_valid_reg;

    logic [QTY_W:0]   fill_sum;
    logic [QTY_W-1:0] fill_sat;

    assign in_beat  = in_beat_t'(s_axis_tdata);
    assign out_free = !m_valid_reg || m_axis_tready;

    olt_slot_mod #(
        .DEPTH (TABLE_DEPTH)
    ) u_slot_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mod_start),
        .in_key    (key_next),
        .out_valid (mod_valid),
        .out_slot  (mod_slot)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (s_axis_tvalid) state_next = FSM_MOD;
            FSM_MOD:  if (mod_valid) state_next = FSM_RMW;
            FSM_RMW:  if (out_free) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == FSM_IDLE);
        mod_start = s_ready && s_axis_tvalid;
        rd_en     = (state_reg == FSM_MOD) && mod_valid;
        commit    = (state_reg == FSM_RMW) && out_free;
    end

    assign key_next = (s_axis_tuser == REQ_CREATE) ? id_counter_reg + 1'b1
                                                   : in_beat.order_ref;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FSM_IDLE;
            id_counter_reg <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mod_start && (s_axis_tuser == REQ_CREATE)) begin
                id_counter_reg <= key_next;
                if (cnt_reg != CW'(TABLE_DEPTH)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mod_start) begin
            req_reg  <= s_axis_tuser;
            beat_reg <= in_beat;
            key_reg  <= key_next;
        end
        if (rd_en) begin
            slot_reg <= mod_slot;
        end
        if (commit) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= slot_mem[mod_slot];
        end
        if (commit && wr_en) begin
            slot_mem[slot_reg] <= wr_entry;
        end
    end

    // ids are handed out in order from 1, so the fill count tells which slots hold data
    assign slot_written = (cnt_reg == CW'(TABLE_DEPTH)) ||
                          ((slot_reg != '0) && (CW'(slot_reg) <= cnt_reg));
    assign found        = slot_written && (rd_entry_reg.id == key_reg);

    assign fill_sum = {1'b0, rd_entry_reg.filled} + {1'b0, beat_reg.fill_amount};
    assign fill_sat = fill_sum[QTY_W] ? '1 : fill_sum[QTY_W-1:0];

    always_comb begin
        wr_entry = rd_entry_reg;
        wr_en    = 1'b0;
        res_next = '0;
        res_next.result_id = key_reg;
        res_next.outcome   = OUT_DONE;
        res_next.exchange_cmd = CMD_NONE;
        if (req_reg == REQ_CREATE) begin
            wr_entry.id     = key_reg;
            wr_entry.symbol = beat_reg.symbol_code;
            wr_entry.price  = beat_reg.price_ticks;
            wr_entry.qty    = beat_reg.order_qty;
            wr_entry.side   = beat_reg.buy_side;
            wr_entry.filled = '0;
            wr_entry.status = ORD_PENDING;
            wr_en = 1'b1;
            res_next.exchange_cmd = CMD_NEW;
        end else if (found) begin
            unique case (req_reg)
                REQ_CANCEL: begin
                    if (rd_entry_reg.status != ORD_PENDING) begin
                        res_next.outcome = OUT_NOT_PENDING;
                    end else begin
                        wr_entry.status = ORD_CANCELED;
                        wr_en = 1'b1;
                        res_next.exchange_cmd = CMD_CANCEL;
                    end
                end
                REQ_MODIFY: begin
                    if (rd_entry_reg.status != ORD_PENDING) begin
                        res_next.outcome = OUT_NOT_PENDING;
                    end else begin
                        wr_entry.price  = beat_reg.price_ticks;
                        wr_entry.qty    = beat_reg.order_qty;
                        wr_entry.filled = '0;
                        wr_entry.status = ORD_PENDING;
                        wr_en = 1'b1;
                        res_next.exchange_cmd = CMD_MODIFY;
                    end
                end
                REQ_UPDATE: begin
                    if (beat_reg.new_state <= ORD_PARTIAL) begin
                        wr_entry.status = beat_reg.new_state;
                    end
                    if (beat_reg.fill_amount != '0) begin
                        wr_entry.filled = fill_sat;
                        wr_entry.status = (fill_sat >= rd_entry_reg.qty) ? ORD_FILLED
                                                                         : ORD_PARTIAL;
                    end
                    wr_en = 1'b1;
                end
                default: begin
                end
            endcase
        end else begin
            res_next.outcome = OUT_NOT_FOUND;
        end
        if ((req_reg == REQ_CREATE) || found) begin
            res_next.out_symbol = wr_entry.symbol;
            res_next.out_price  = wr_entry.price;
            res_next.out_qty    = wr_entry.qty;
            res_next.out_side   = wr_entry.side;
            res_next.out_state  = wr_entry.status;
            res_next.out_filled = wr_entry.filled;
            res_next.active     = (wr_entry.status == ORD_PENDING) ||
                                  (wr_entry.status == ORD_PARTIAL);
        end
    end

    assign s_axis_tready = s_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(res_reg);

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    a_write_in_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && wr_en) |-> (state_reg == FSM_RMW))
        else $error("slot memory written outside write-back");

    a_fill_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_slot_ready_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_valid |-> (state_reg == FSM_MOD))
        else $error("slot index arrived outside lookup");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_axis_tvalid)
        else $error("finished result not presented");
`endif

endmodule
